FILE: hw/rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared types and constants of the greedy coin change block
// Holds the data width, command codes, control state and cell control struct.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int unsigned DW = 16;

  typedef logic [DW-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_PUSH,
    ST_FIN
  } state_t;

  // Control broadcast to every cell of the coin chain.
  typedef struct packed {
    logic  insert;
    logic  clear;
    logic  rotate;
    word_t value;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/gcc_cell.sv
// ----------------------------------------------------------------------------
// gcc_cell: one entry of the coin chain
// Holds one denomination; clears, inserts in sorted order or rotates toward the head.
// ----------------------------------------------------------------------------
module gcc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  gcc_pkg::cell_ctl_t ctl,
  input  gcc_pkg::word_t     prev_coin,
  input  logic               prev_valid,
  input  logic               prev_ge,
  input  gcc_pkg::word_t     next_coin,
  input  logic               next_valid,
  output gcc_pkg::word_t     coin,
  output logic               valid,
  output logic               ge
);
  import gcc_pkg::*;

  word_t coin_r, coin_nxt;
  logic  valid_r, valid_nxt;

  // This cell lies at or after the insertion point of the new value.
  assign ge = !(valid_r && (coin_r >= ctl.value));

  always_comb begin
    coin_nxt  = coin_r;
    valid_nxt = valid_r;
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.rotate) begin
      coin_nxt  = next_coin;
      valid_nxt = next_valid;
    end else if (ctl.insert) begin
      if (prev_ge) begin
        coin_nxt  = prev_coin;
        valid_nxt = prev_valid;
      end else if (ge) begin
        coin_nxt  = ctl.value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    coin_r <= coin_nxt;
  end

  assign coin  = coin_r;
  assign valid = valid_r;

endmodule

FILE: hw/rtl/gcc_div.sv
// ----------------------------------------------------------------------------
// gcc_div: iterative restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder ready.
// ----------------------------------------------------------------------------
module gcc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  gcc_pkg::word_t dividend,
  input  gcc_pkg::word_t divisor,
  output logic           done,
  output gcc_pkg::word_t quot,
  output gcc_pkg::word_t remd
);
  import gcc_pkg::*;

  localparam int unsigned CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  word_t         a_r, a_nxt;
  word_t         d_r, d_nxt;
  logic [DW:0]   p_r, p_nxt;
  logic [DW:0]   p_sh, diff;

  always_comb begin
    p_sh      = {p_r[DW-1:0], a_r[DW-1]};
    diff      = p_sh - {1'b0, d_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    p_nxt     = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = dividend;
      d_nxt    = divisor;
      p_nxt    = '0;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        p_nxt = diff;
        a_nxt = {a_r[DW-2:0], 1'b1};
      end else begin
        p_nxt = p_sh;
        a_nxt = {a_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    d_r <= d_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign quot = a_r;
  assign remd = p_r[DW-1:0];

endmodule

FILE: hw/rtl/greedy_coin_change.sv
// ----------------------------------------------------------------------------
// greedy_coin_change: greedy change maker over a sorted coin table
// Chain of coin cells in descending order plus a shared serial divider.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall, in_cmd, in_value) takes one
// command item at a time. An add item inserts its denomination at its sorted
// place; a zero value, an add to a full table and the unused command code
// are dropped. A clear item empties the table. A change item walks the table
// largest coin first: the chain rotates one cell per step so that every coin
// passes the head cell, and the head coin is divided into the remaining
// amount by a one-bit-per-cycle divider. Each coin used gives one result
// item on the output channel (out_valid, out_stall, out_coin_count,
// out_coin_value, out_unpaid, out_last); the last item carries the unpaid
// remainder. The last result item appears as the block returns to idle.
// in_stall is high while a change item is in work. Reset empties the table
// and drops any result in flight. A stalled output holds its item and the
// sequencer waits for the slot.
// ----------------------------------------------------------------------------
module greedy_coin_change #(
  parameter int unsigned MAX_COINS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_cmd,
  input  gcc_pkg::word_t in_value,
  output logic           out_valid,
  input  logic           out_stall,
  output gcc_pkg::word_t out_coin_count,
  output gcc_pkg::word_t out_coin_value,
  output gcc_pkg::word_t out_unpaid,
  output logic           out_last
);
  import gcc_pkg::*;

  localparam int unsigned STW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

  state_t    state_r, state_nxt;
  logic [STW-1:0] step_r, step_nxt;
  word_t     rem_r, rem_nxt;
  logic      pend_r, pend_nxt;
  word_t     pcnt_r, pcnt_nxt;
  word_t     pcoin_r, pcoin_nxt;
  word_t     ncnt_r, ncnt_nxt;
  word_t     ncoin_r, ncoin_nxt;
  logic      ov_r, ov_nxt;
  word_t     ocnt_r, ocnt_nxt;
  word_t     ocoin_r, ocoin_nxt;
  word_t     ounp_r, ounp_nxt;
  logic      olast_r, olast_nxt;

  cell_ctl_t ctl;
  word_t     c_coin  [MAX_COINS];
  logic      c_valid [MAX_COINS];
  logic      c_ge    [MAX_COINS];

  logic      div_start, div_done;
  word_t     div_q, div_r;
  logic      accept, slot_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !ov_r || !out_stall;

  // The coin chain: cell 0 is the head and holds the largest coin.
  for (genvar i = 0; i < MAX_COINS; i++) begin : g_cell
    localparam int unsigned NX = (i + 1) % MAX_COINS;
    localparam int unsigned PV = (i == 0) ? 0 : i - 1;
    gcc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_coin (c_coin[PV]),
      .prev_valid(c_valid[PV]),
      .prev_ge   ((i == 0) ? 1'b0 : c_ge[PV]),
      .next_coin (c_coin[NX]),
      .next_valid(c_valid[NX]),
      .coin      (c_coin[i]),
      .valid     (c_valid[i]),
      .ge        (c_ge[i])
    );
  end

  gcc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(rem_r),
    .divisor (c_coin[0]),
    .done    (div_done),
    .quot    (div_q),
    .remd    (div_r)
  );

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    pcoin_nxt  = pcoin_r;
    ncnt_nxt   = ncnt_r;
    ncoin_nxt  = ncoin_r;
    ov_nxt     = ov_r && out_stall;
    ocnt_nxt   = ocnt_r;
    ocoin_nxt  = ocoin_r;
    ounp_nxt   = ounp_r;
    olast_nxt  = olast_r;
    ctl.insert = 1'b0;
    ctl.clear  = 1'b0;
    ctl.rotate = 1'b0;
    ctl.value  = in_value;
    div_start  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_ADD: begin
              ctl.insert = (in_value != '0) && !c_valid[MAX_COINS-1];
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            CMD_CHANGE: begin
              rem_nxt   = in_value;
              step_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (c_valid[0] && (rem_r != '0) && (c_coin[0] <= rem_r)) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          ctl.rotate = 1'b1;
          step_nxt   = step_r + 1'b1;
          if (step_r == STW'(MAX_COINS - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ncnt_nxt  = div_q;
          ncoin_nxt = c_coin[0];
          rem_nxt   = div_r;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // An earlier result leaves only now that a later one proves it not last.
        if (!pend_r || slot_free) begin
          if (pend_r) begin
            ov_nxt    = 1'b1;
            ocnt_nxt  = pcnt_r;
            ocoin_nxt = pcoin_r;
            ounp_nxt  = '0;
            olast_nxt = 1'b0;
          end
          pend_nxt   = 1'b1;
          pcnt_nxt   = ncnt_r;
          pcoin_nxt  = ncoin_r;
          ctl.rotate = 1'b1;
          step_nxt   = step_r + 1'b1;
          state_nxt  = (step_r == STW'(MAX_COINS - 1)) ? ST_FIN : ST_SCAN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocnt_nxt  = pend_r ? pcnt_r : '0;
          ocoin_nxt = pend_r ? pcoin_r : '0;
          ounp_nxt  = rem_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
    end
    rem_r   <= rem_nxt;
    pcnt_r  <= pcnt_nxt;
    pcoin_r <= pcoin_nxt;
    ncnt_r  <= ncnt_nxt;
    ncoin_r <= ncoin_nxt;
    ocnt_r  <= ocnt_nxt;
    ocoin_r <= ocoin_nxt;
    ounp_r  <= ounp_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_coin_count = ocnt_r;
  assign out_coin_value = ocoin_r;
  assign out_unpaid     = ounp_r;
  assign out_last       = olast_r;

endmodule
